FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the 3x3 image filter.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define KIF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kif assertion failed");

// Checked at every edge, reset included.
`define KIF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("kif assertion failed during reset");

`endif

FILE: hw/rtl/kif_pkg.sv
// Package of the 3x3 image filter: constants, payload and control types, helpers.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package kif_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int GeomW    = 11;
  localparam int RowW     = GeomW + 1;
  localparam int PixW     = 8;
  localparam int CoefW    = 16;
  localparam int CoefRegW = 48;
  localparam int FracBits = 12;
  localparam int ProdW    = PixW + CoefW;
  localparam int RowSumW  = ProdW + 2;
  localparam int SumW     = ProdW + 4;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);
  localparam int ODepth   = 8;
  localparam int OPtrW    = $clog2(ODepth);
  localparam int OCntW    = $clog2(ODepth + 1);
  localparam int CfgIdxW  = 3;

  localparam logic [GeomW-1:0]    WidthReset  = 11'd640;
  localparam logic [GeomW-1:0]    HeightReset = 11'd480;
  localparam logic [CoefRegW-1:0] CoeffReset  = 48'h01C7_01C7_01C7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_FLIP_KERNEL,
    CFG_COEFF_TOP,
    CFG_COEFF_MIDDLE,
    CFG_COEFF_BOTTOM
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_EDGE_LOAD,
    OP_SHIFT,
    OP_SHIFT_EMIT,
    OP_DRAIN
  } op_e;

  typedef struct packed {
    logic            req_type;
    logic [PixW-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_out;
    logic            row_last;
    logic            frame_last;
  } out_item_t;

  typedef struct packed {
    logic [GeomW-1:0]    image_width;
    logic [GeomW-1:0]    image_height;
    logic                flip_kernel;
    logic [CoefRegW-1:0] coeff_top_row;
    logic [CoefRegW-1:0] coeff_middle_row;
    logic [CoefRegW-1:0] coeff_bottom_row;
  } cfg_t;

  typedef struct packed {
    op_e             op;
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } q_entry_t;

  function automatic logic [CoefW-1:0] coeff_at(cfg_t cfg, logic [1:0] r, logic [1:0] c);
    logic [CoefRegW-1:0] row_bits;
    logic [CoefW-1:0]    val;
    case (r)
      2'd0:    row_bits = cfg.coeff_top_row;
      2'd1:    row_bits = cfg.coeff_middle_row;
      default: row_bits = cfg.coeff_bottom_row;
    endcase
    case (c)
      2'd0:    val = row_bits[3*CoefW-1:2*CoefW];
      2'd1:    val = row_bits[2*CoefW-1:CoefW];
      default: val = row_bits[CoefW-1:0];
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kernel_3x3_image_filter.sv
// Top level of the 3x3 image filter: configuration registers and the two halves.
// Depends on kif_pkg, kif_front, kif_queue and kif_back.
//
// Usage: pixels of an 8-bit grayscale image enter in raster order through a
// queue-like port (push/full); a transfer happens when push is high and full is low.
// Filtered pixels leave through empty/pop; the head result is valid while empty is
// low and is transferred when pop is high. Output lags the input by one row plus
// one pixel; after the last pixel of a frame, image_width + 1 flush items drain it.
// One item is taken per clock while full is low; the line store is one dual-use
// memory whose read-modify-write per column is pipelined and forwarded, so
// throughput stays at one item per cycle. Reset clears the position counters, the
// window and all queues, and restores the register defaults; the line store is not
// cleared. When the receiver stalls, up to eight results wait in the output queue
// and four operations in the middle queue; full then rises and holds input back.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while idle.
`timescale 1ns / 1ps
`default_nettype none

module kernel_3x3_image_filter import kif_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CoefRegW-1:0] cfg_data_i
);

  cfg_t             cfg_q, cfg_d;
  logic             accept;
  logic             entry_valid, entry_pop, q_valid;
  q_entry_t         entry, q_entry;
  logic [QCntW-1:0] q_count;

  assign full   = ((QCntW+1)'(q_count) + (QCntW+1)'(entry_valid)) >= (QCntW+1)'(QDepth);
  assign accept = push && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  cfg_d.image_width      = cfg_data_i[GeomW-1:0];
        CFG_IMAGE_HEIGHT: cfg_d.image_height     = cfg_data_i[GeomW-1:0];
        CFG_FLIP_KERNEL:  cfg_d.flip_kernel      = cfg_data_i[0];
        CFG_COEFF_TOP:    cfg_d.coeff_top_row    = cfg_data_i;
        CFG_COEFF_MIDDLE: cfg_d.coeff_middle_row = cfg_data_i;
        CFG_COEFF_BOTTOM: cfg_d.coeff_bottom_row = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= WidthReset;
      cfg_q.image_height     <= HeightReset;
      cfg_q.flip_kernel      <= 1'b0;
      cfg_q.coeff_top_row    <= CoeffReset;
      cfg_q.coeff_middle_row <= CoeffReset;
      cfg_q.coeff_bottom_row <= CoeffReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  kif_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .in_item_i,
    .entry_valid_o (entry_valid),
    .entry_o       (entry)
  );

  kif_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_valid_i (entry_valid),
    .wr_entry_i (entry),
    .rd_pop_i   (entry_pop),
    .rd_valid_o (q_valid),
    .rd_entry_o (q_entry),
    .count_o    (q_count)
  );

  kif_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .entry_valid_i (q_valid),
    .entry_i       (q_entry),
    .entry_pop_o   (entry_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_item_o
  );

endmodule

`default_nettype wire

FILE: hw/rtl/kif_queue.sv
// Short queue of classified window operations between front and back end.
// Depends on kif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kif_queue import kif_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  q_entry_t         wr_entry_i,
  input  logic             rd_pop_i,
  output logic             rd_valid_o,
  output q_entry_t         rd_entry_o,
  output logic [QCntW-1:0] count_o
);

  q_entry_t         mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop     = rd_pop_i && (cnt_q != '0);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_entry_o = mem_q[rptr_q];
  assign count_o    = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_valid_i && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!wr_valid_i && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_valid_i) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wptr_q] <= wr_entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kif_front.sv
// Front end: raster position tracking, item classification and the line store.
// Depends on kif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kif_front import kif_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     accept_i,
  input  in_item_t in_item_i,
  output logic     entry_valid_o,
  output q_entry_t entry_o
);

  logic [ColW-1:0]   col_q, col_d, col_c;
  logic [RowW-1:0]   row_q, row_d, row_c, h_p1;
  logic [GeomW-1:0]  w_eff, h_eff, col_inc;
  logic              row_lt_h, is_drain, active;
  op_e               op_c;

  logic              s1_valid_q, s1_we_q, s1_top_old_q, s1_bot_pix_q;
  op_e               s1_op_q;
  logic [ColW-1:0]   s1_addr_q;
  logic [PixW-1:0]   s1_pix_q;
  logic              fwd_q;
  logic [2*PixW-1:0] fwd_data_q, mem_rd_q, rd_data, wr_data;
  logic              s1_we;
  logic [PixW-1:0]   older, newer;

  logic [2*PixW-1:0] line_mem [MaxWidth];

  always_comb begin
    w_eff = cfg_i.image_width;
    if (w_eff == '0) begin
      w_eff = GeomW'(1);
    end else if (w_eff > GeomW'(MaxWidth)) begin
      w_eff = GeomW'(MaxWidth);
    end
    h_eff = (cfg_i.image_height == '0) ? GeomW'(1) : cfg_i.image_height;
    h_p1  = RowW'(h_eff) + RowW'(1);
    row_c = (row_q > h_p1) ? h_p1 : row_q;
    if (GeomW'(col_q) >= w_eff) begin
      col_c = ColW'(w_eff - GeomW'(1));
    end else begin
      col_c = col_q;
    end
    is_drain = (row_c == h_p1);
    if (is_drain) begin
      col_c = '0;
    end
    row_lt_h = (row_c < RowW'(h_eff));
    active   = in_item_i.req_type ? !row_lt_h : row_lt_h;
    col_inc  = GeomW'(col_c) + GeomW'(1);
  end

  always_comb begin
    row_d = row_c;
    col_d = col_c;
    if (active) begin
      if (is_drain) begin
        row_d = '0;
        col_d = '0;
      end else if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = row_c + RowW'(1);
      end else begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  always_comb begin
    if (is_drain) begin
      op_c = OP_DRAIN;
    end else if (col_c == '0) begin
      op_c = (row_c >= RowW'(2)) ? OP_EDGE_LOAD : OP_LOAD;
    end else begin
      op_c = (row_c >= RowW'(1)) ? OP_SHIFT_EMIT : OP_SHIFT;
    end
  end

  assign s1_we   = s1_valid_q && s1_we_q;
  assign rd_data = fwd_q ? fwd_data_q : mem_rd_q;
  assign older   = rd_data[2*PixW-1:PixW];
  assign newer   = rd_data[PixW-1:0];
  assign wr_data = {newer, s1_pix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
        fwd_q <= s1_we && (s1_addr_q == col_c);
      end
      s1_valid_q <= accept_i && active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_op_q      <= op_c;
      s1_addr_q    <= col_c;
      s1_pix_q     <= in_item_i.pixel_in;
      s1_we_q      <= row_lt_h;
      s1_top_old_q <= (row_c >= RowW'(2));
      s1_bot_pix_q <= row_lt_h;
      fwd_data_q   <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem_rd_q <= line_mem[col_c];
    end
    if (s1_we) begin
      line_mem[s1_addr_q] <= wr_data;
    end
  end

  assign entry_valid_o = s1_valid_q;
  assign entry_o.op    = s1_op_q;
  assign entry_o.top   = s1_top_old_q ? older : newer;
  assign entry_o.mid   = newer;
  assign entry_o.bot   = s1_bot_pix_q ? s1_pix_q : newer;

endmodule

`default_nettype wire

FILE: hw/rtl/kif_back.sv
// Back end: 3x3 window, pipelined multiply-accumulate, saturation and result queue.
// Depends on kif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kif_back import kif_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      entry_valid_i,
  input  q_entry_t  entry_i,
  output logic      entry_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_item_o
);

  logic [2:0][2:0][PixW-1:0] win_q, win_d, shifted, emit_win;
  logic [2:0][PixW-1:0]      new_col;
  logic                      emit;

  logic                      s0_v_q, s1_v_q, s2_v_q, s3_v_q;
  logic [2:0][2:0][PixW-1:0] s0_win_q;
  logic                      s0_rl_q, s0_fl_q, s1_rl_q, s1_fl_q;
  logic                      s2_rl_q, s2_fl_q, s3_rl_q, s3_fl_q;
  logic signed [ProdW-1:0]   px_ext [9];
  logic signed [ProdW-1:0]   cf_ext [9];
  logic signed [ProdW-1:0]   prod_d [9];
  logic signed [ProdW-1:0]   prod_q [9];
  logic signed [RowSumW-1:0] rsum_d [3];
  logic signed [RowSumW-1:0] rsum_q [3];
  logic signed [SumW-1:0]    sum_q;
  logic [CoefW-1:0]          cf_bits [9];
  logic [PixW-1:0]           sat;

  out_item_t                 omem_q [ODepth];
  logic [OPtrW-1:0]          owptr_q, orptr_q;
  logic [OCntW-1:0]          ocnt_q;
  logic [OCntW:0]            in_use;
  logic                      opop;

  assign new_col[0] = entry_i.top;
  assign new_col[1] = entry_i.mid;
  assign new_col[2] = entry_i.bot;

  assign in_use = (OCntW+1)'(ocnt_q) + (OCntW+1)'(s0_v_q) + (OCntW+1)'(s1_v_q)
                + (OCntW+1)'(s2_v_q) + (OCntW+1)'(s3_v_q);
  assign entry_pop_o = entry_valid_i && (in_use < (OCntW+1)'(ODepth));

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted[r][0] = win_q[r][1];
      shifted[r][1] = win_q[r][2];
      shifted[r][2] = win_q[r][2];
    end
    win_d    = win_q;
    emit_win = shifted;
    emit     = 1'b0;
    case (entry_i.op)
      OP_LOAD: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win_d[r][c] = new_col[r];
          end
        end
      end
      OP_EDGE_LOAD: begin
        emit = 1'b1;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win_d[r][c] = new_col[r];
          end
        end
      end
      OP_SHIFT: begin
        win_d = shifted;
        for (int r = 0; r < 3; r++) begin
          win_d[r][2] = new_col[r];
        end
      end
      OP_SHIFT_EMIT: begin
        emit  = 1'b1;
        win_d = shifted;
        for (int r = 0; r < 3; r++) begin
          win_d[r][2] = new_col[r];
        end
        emit_win = win_d;
      end
      OP_DRAIN: begin
        emit  = 1'b1;
        win_d = shifted;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        cf_bits[a*3+b] = cfg_i.flip_kernel ? coeff_at(cfg_i, 2'(2 - a), 2'(2 - b))
                                           : coeff_at(cfg_i, 2'(a), 2'(b));
        px_ext[a*3+b]  = $signed({{(ProdW-PixW){1'b0}}, s0_win_q[a][b]});
        cf_ext[a*3+b]  = $signed({{(ProdW-CoefW){cf_bits[a*3+b][CoefW-1]}},
                                  cf_bits[a*3+b]});
        prod_d[a*3+b]  = px_ext[a*3+b] * cf_ext[a*3+b];
      end
    end
    for (int a = 0; a < 3; a++) begin
      rsum_d[a] = RowSumW'(prod_q[a*3]) + RowSumW'(prod_q[a*3+1])
                + RowSumW'(prod_q[a*3+2]);
    end
  end

  always_comb begin
    if (sum_q[SumW-1]) begin
      sat = '0;
    end else if (|sum_q[SumW-2:FracBits+PixW]) begin
      sat = '1;
    end else begin
      sat = sum_q[FracBits+PixW-1:FracBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (entry_pop_o) begin
        win_q <= win_d;
      end
      s0_v_q <= entry_pop_o && emit;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_win_q <= emit_win;
    s0_rl_q  <= (entry_i.op == OP_EDGE_LOAD) || (entry_i.op == OP_DRAIN);
    s0_fl_q  <= (entry_i.op == OP_DRAIN);
    prod_q   <= prod_d;
    s1_rl_q  <= s0_rl_q;
    s1_fl_q  <= s0_fl_q;
    rsum_q   <= rsum_d;
    s2_rl_q  <= s1_rl_q;
    s2_fl_q  <= s1_fl_q;
    sum_q    <= SumW'(rsum_q[0]) + SumW'(rsum_q[1]) + SumW'(rsum_q[2]);
    s3_rl_q  <= s2_rl_q;
    s3_fl_q  <= s2_fl_q;
  end

  assign opop       = pop_i && (ocnt_q != '0);
  assign empty_o    = (ocnt_q == '0);
  assign out_item_o = omem_q[orptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      if (s3_v_q) begin
        owptr_q <= owptr_q + OPtrW'(1);
      end
      if (opop) begin
        orptr_q <= orptr_q + OPtrW'(1);
      end
      if (s3_v_q && !opop) begin
        ocnt_q <= ocnt_q + OCntW'(1);
      end else if (!s3_v_q && opop) begin
        ocnt_q <= ocnt_q - OCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      omem_q[owptr_q] <= '{pixel_out: sat, row_last: s3_rl_q, frame_last: s3_fl_q};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kif_checker.sv
// Port-level checker of the 3x3 image filter, bound to the top level.
// Depends on kif_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kif_checker import kif_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  `KIF_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> empty)
  `KIF_ASSERT_ALWAYS(a_not_full_in_reset, clk_i, !rst_ni |-> !full)
  `KIF_ASSERT(a_full_needs_push, clk_i, rst_ni, !full && !push |=> !full)
  `KIF_ASSERT(a_result_holds, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(out_item_o))

endmodule

bind kernel_3x3_image_filter kif_checker u_kif_checker (.*);

`default_nettype wire

FILE: bench/kernel_3x3_image_filter_checker.sv
// Checker for the 3x3 image filter: watches the pixel, result and register ports,
// predicts every filtered pixel and compares it with the one the block returns.
// Depends on kif_pkg; instantiated by kernel_3x3_image_filter_tb beside the block.
`timescale 1ns / 1ps
`default_nettype none

module kernel_3x3_image_filter_checker import kif_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  in_item_t            in_item_i,
  input  logic                empty,
  input  logic                pop,
  input  out_item_t           out_item_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CoefRegW-1:0] cfg_data_i,
  output int                  pending_o,
  output int                  errors_o
);

  logic [PixW-1:0]     older_line [MaxWidth];
  logic [PixW-1:0]     newer_line [MaxWidth];
  logic [PixW-1:0]     win [9];
  int unsigned         in_col, in_row;
  logic [GeomW-1:0]    width_q, height_q;
  logic                flip_q;
  logic [CoefRegW-1:0] coef_rows [3];
  out_item_t           filtered_q [$];

  function automatic int coef(int r, int c);
    logic signed [CoefW-1:0] v;
    v = coef_rows[r][16*(2-c) +: 16];
    return int'(v);
  endfunction

  task automatic shift_win();
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
  endtask

  task automatic add_filtered(int unsigned orow, int unsigned ocol, int unsigned w,
                              int unsigned h);
    int        acc;
    int        q;
    out_item_t res;
    acc = 0;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        acc += int'(win[a*3+b]) * (flip_q ? coef(2-a, 2-b) : coef(a, b));
    q = acc / (1 << FracBits);
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    res.pixel_out  = q[PixW-1:0];
    res.row_last   = (ocol == w - 1);
    res.frame_last = (ocol == w - 1) && (orow == h - 1);
    filtered_q.push_back(res);
  endtask

  task automatic filter_step(in_item_t it);
    int unsigned w, h, r, c;
    logic [PixW-1:0] top, mid, bot;
    w = width_q;
    h = height_q;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    if (h < 1) h = 1;
    if (in_col >= w) in_col = w - 1;
    if (in_row > h + 1) in_row = h + 1;
    if (in_row == h + 1) in_col = 0;
    r = in_row;
    c = in_col;
    if (!it.req_type && r >= h) return;
    if (it.req_type && r < h) return;
    if (r == h + 1) begin
      shift_win();
      add_filtered(r - 2, w - 1, w, h);
      in_row = 0;
      in_col = 0;
      return;
    end
    if (c == 0 && r >= 2) begin
      shift_win();
      add_filtered(r - 2, w - 1, w, h);
    end
    mid = newer_line[c];
    top = (r >= 2) ? older_line[c] : mid;
    bot = (r < h) ? it.pixel_in : mid;
    if (c == 0) begin
      for (int i = 0; i < 3; i++) begin
        win[i] = top;
        win[3+i] = mid;
        win[6+i] = bot;
      end
    end else begin
      shift_win();
      win[2] = top;
      win[5] = mid;
      win[8] = bot;
      if (r >= 1) add_filtered(r - 1, c - 1, w, h);
    end
    if (r < h) begin
      older_line[c] = newer_line[c];
      newer_line[c] = it.pixel_in;
    end
    in_col = c + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row = r + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      width_q   = WidthReset;
      height_q  = HeightReset;
      flip_q    = 1'b0;
      coef_rows = '{CoeffReset, CoeffReset, CoeffReset};
      for (int i = 0; i < MaxWidth; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      in_col = 0;
      in_row = 0;
      filtered_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH:  width_q = cfg_data_i[GeomW-1:0];
          CFG_IMAGE_HEIGHT: height_q = cfg_data_i[GeomW-1:0];
          CFG_FLIP_KERNEL:  flip_q = cfg_data_i[0];
          CFG_COEFF_TOP:    coef_rows[0] = cfg_data_i;
          CFG_COEFF_MIDDLE: coef_rows[1] = cfg_data_i;
          CFG_COEFF_BOTTOM: coef_rows[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (push && !full) filter_step(in_item_i);
      if (pop && !empty) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_item_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_item = filtered_q.pop_front();
          if (exp_item.pixel_out !== out_item_i.pixel_out ||
              exp_item.row_last !== out_item_i.row_last ||
              exp_item.frame_last !== out_item_i.frame_last) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, exp_item,
                     out_item_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= filtered_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: bench/kernel_3x3_image_filter_tb.sv
// Top of the 3x3 image filter testbench: clock, reset, register setup, pixel frames
// with bursty input and stalling output, watchdog and verdict.
// Depends on kif_pkg, kernel_3x3_image_filter and kernel_3x3_image_filter_checker.
`timescale 1ns / 1ps
`default_nettype none

module kernel_3x3_image_filter_tb;
  import kif_pkg::*;

  localparam int StallLimit = 5000;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  in_item_t            in_item;
  logic                empty;
  logic                pop;
  out_item_t           out_item;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CoefRegW-1:0] cfg_data;
  int                  pending;
  int                  errors;
  int                  sent;
  int                  burst_left;
  int                  quiet_cycles;
  int                  pop_mode;
  int                  mode_left;

  kernel_3x3_image_filter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  kernel_3x3_image_filter_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop       <= 1'b0;
      pop_mode  <= 0;
      mode_left <= 50;
    end else begin
      if (mode_left == 0) begin
        pop_mode  <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (pop_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("kernel_3x3_image_filter_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put(logic kind, logic [PixW-1:0] pix);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    push <= 1'b1;
    in_item <= '{req_type: kind, pixel_in: pix};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    burst_left--;
    sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CoefRegW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PixW-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CoefRegW-1:0] rand_coef_row();
    logic [CoefRegW-1:0] row;
    logic [CoefW-1:0]    v;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 4) == 0) v = CoefW'($urandom);
      else begin
        v = CoefW'($urandom_range(0, 2048));
        if ($urandom_range(0, 2) == 0) v = -v;
      end
      row[16*i +: 16] = v;
    end
    return row;
  endfunction

  task automatic setup(logic [GeomW-1:0] w, logic [GeomW-1:0] h, logic flip,
                       logic [CoefRegW-1:0] ct, logic [CoefRegW-1:0] cm,
                       logic [CoefRegW-1:0] cb);
    write_reg(CFG_IMAGE_WIDTH, CoefRegW'(w));
    write_reg(CFG_IMAGE_HEIGHT, CoefRegW'(h));
    write_reg(CFG_FLIP_KERNEL, CoefRegW'(flip));
    write_reg(CFG_COEFF_TOP, ct);
    write_reg(CFG_COEFF_MIDDLE, cm);
    write_reg(CFG_COEFF_BOTTOM, cb);
  endtask

  task automatic run_frame(int w, int h, bit noise);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        if (noise && $urandom_range(0, 40) == 0) put(1'b1, PixW'($urandom_range(0, 255)));
        put(1'b0, rand_pixel());
      end
    for (int f = 0; f <= w; f++) begin
      if (noise && $urandom_range(0, 20) == 0) put(1'b0, PixW'($urandom_range(0, 255)));
      put(1'b1, PixW'($urandom_range(0, 255)));
    end
  endtask

  function automatic int eff_dim(logic [GeomW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxWidth) return MaxWidth;
    return int'(v);
  endfunction

  initial begin
    logic [GeomW-1:0] w, h;
    int round;
    rst_ni     = 1'b0;
    push       = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    sent       = 0;
    burst_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity kernel on a tiny frame, with a flush inside the frame and a pixel
    // inside the drain, both of which must be ignored.
    setup(11'd3, 11'd2, 1'b0, 48'h0, 48'h0000_1000_0000, 48'h0);
    put(1'b1, 8'hA5);
    put(1'b0, 8'd0);   put(1'b0, 8'd255); put(1'b0, 8'd128);
    put(1'b0, 8'd255); put(1'b0, 8'd0);   put(1'b0, 8'd1);
    put(1'b1, 8'd0);   put(1'b0, 8'd77);  put(1'b1, 8'd255);
    put(1'b1, 8'd0);   put(1'b1, 8'd0);
    settle();
    // Single pixel image, convolution mode, saturation high and low.
    setup(11'd1, 11'd1, 1'b1, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h0);
    put(1'b0, 8'd255); put(1'b1, 8'd0); put(1'b1, 8'd0);
    settle();
    setup(11'd2, 11'd2, 1'b1, 48'h8000_8000_8000, 48'h1000_0000_0000, 48'h0001_0000_0000);
    run_frame(2, 2, 1'b0);
    settle();
    // Geometry shrinks in the middle of a frame.
    setup(11'd6, 11'd5, 1'b0, rand_coef_row(), rand_coef_row(), rand_coef_row());
    for (int i = 0; i < 20; i++) put(1'b0, rand_pixel());
    settle();
    write_reg(CFG_IMAGE_WIDTH, CoefRegW'(11'd3));
    write_reg(CFG_IMAGE_HEIGHT, CoefRegW'(11'd3));
    for (int i = 0; i < 5; i++) put(1'b1, 8'd0);
    settle();

    round = 0;
    while (sent < 2000 || round < 8) begin
      if (round == 3) begin
        w = 11'd2047;
        h = 11'd0;
      end else if (round == 6) begin
        w = 11'd0;
        h = 11'd5;
      end else begin
        w = ($urandom_range(0, 9) == 0) ? GeomW'($urandom_range(17, 100))
                                        : GeomW'($urandom_range(1, 16));
        h = GeomW'($urandom_range(1, 8));
      end
      setup(w, h, 1'($urandom_range(0, 1)), rand_coef_row(), rand_coef_row(),
            rand_coef_row());
      repeat ((round == 3) ? 1 : $urandom_range(1, 3))
        run_frame(eff_dim(w), eff_dim(h), 1'b1);
      settle();
      round++;
    end

    if (errors == 0) $display("kernel_3x3_image_filter_tb passed");
    else $display("kernel_3x3_image_filter_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/kif_pkg.sv
hw/rtl/kif_queue.sv
hw/rtl/kif_front.sv
hw/rtl/kif_back.sv
hw/rtl/kernel_3x3_image_filter.sv
hw/rtl/kif_checker.sv
bench/kernel_3x3_image_filter_checker.sv
bench/kernel_3x3_image_filter_tb.sv
